/* design/clx_pkg.sv */
package clx_pkg;

  localparam int REQ_W   = 3;
  localparam int VAL_W   = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 7;
  localparam int DROWS_W = 3;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_DATA      = 3'd0,
    REQ_INSTR     = 3'd1,
    REQ_SETCUR    = 3'd2,
    REQ_HOME      = 3'd3,
    REQ_CLEAR     = 3'd4,
    REQ_BACKLIGHT = 3'd5
  } req_e;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_EXP_ADDR = 2'd0;
  localparam logic [1:0] REG_ROWS     = 2'd1;
  localparam logic [1:0] REG_COLS     = 2'd2;

  localparam logic [BYTE_W-1:0] CMD_HOME  = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_CLEAR = 8'h01;
  localparam logic [COL_W-1:0]  COL_MAX   = 7'd127;

  localparam logic [DROWS_W-1:0] ROWS_RST = 3'd2;
  localparam logic [COL_W-1:0]   COLS_RST = 7'd16;

  // expander pin positions
  localparam int PIN_RS = 0;
  localparam int PIN_E  = 2;
  localparam int PIN_BL = 3;

  // work item handed from front to back
  typedef struct packed {
    logic              bl;     // backlight update, single byte
    logic              bl_on;
    logic [BYTE_W-1:0] b0;
    logic              rs0;
    logic              two;    // second byte (instruction, RS low) follows
    logic [BYTE_W-1:0] b1;
  } job_t;

  // set-DDRAM-address: row*0x40 keeps only row[0] inside seven bits
  function automatic logic [BYTE_W-1:0] ddram_cmd(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    logic [COL_W-1:0] a;
    a = {r[0], 6'd0} + c;
    return {1'b1, a};
  endfunction

endpackage

/* design/clx_if.sv */
interface clx_req_if;
  logic                        valid;
  logic                        ready;
  logic [clx_pkg::REQ_W-1:0]   req_type;
  logic [clx_pkg::VAL_W-1:0]   value;
  logic [clx_pkg::COL_W-1:0]   col;
  logic [clx_pkg::ROW_W-1:0]   row;

  modport source (output valid, req_type, value, col, row, input ready);
  modport sink   (input valid, req_type, value, col, row, output ready);
endinterface

interface clx_byte_if;
  logic                        valid;
  logic                        ready;
  logic [clx_pkg::BYTE_W-1:0]  expander_byte;
  logic [clx_pkg::ADDR_W-1:0]  bus_address;
  logic                        last;

  modport source (output valid, expander_byte, bus_address, last, input ready);
  modport sink   (input valid, expander_byte, bus_address, last, output ready);
endinterface

/* design/clx_front.sv */
module clx_front (
  input  logic                          clk,
  input  logic                          rst_n,
  clx_req_if.sink                       in_req,
  input  logic [clx_pkg::DROWS_W-1:0]   display_rows,
  input  logic [clx_pkg::COL_W-1:0]     display_cols,
  input  logic                          q_full,
  output logic                          q_push,
  output clx_pkg::job_t                 q_job
);
  import clx_pkg::*;

  logic [COL_W-1:0]   col_r, col_nxt, col_inc;
  logic [ROW_W-1:0]   row_r, row_nxt, row_wrap;
  logic [DROWS_W-1:0] nr;
  logic               wrap, xfer;

  assign in_req.ready = !q_full;
  assign xfer = in_req.valid && in_req.ready;

  always_comb begin
    col_inc = (col_r != COL_MAX) ? col_r + 7'd1 : col_r;
    wrap    = (display_cols != '0) && (col_inc == display_cols);
    nr      = {1'b0, row_r} + 3'd1;
    if (nr == display_rows || nr[2]) begin
      row_wrap = '0;
    end else begin
      row_wrap = nr[ROW_W-1:0];
    end
  end

  always_comb begin
    q_job   = '0;
    q_push  = 1'b0;
    col_nxt = col_r;
    row_nxt = row_r;
    case (req_e'(in_req.req_type))
      REQ_DATA: begin
        q_push    = xfer;
        q_job.b0  = in_req.value;
        q_job.rs0 = 1'b1;
        if (wrap) begin
          q_job.two = 1'b1;
          q_job.b1  = ddram_cmd(row_wrap, '0);
          col_nxt   = '0;
          row_nxt   = row_wrap;
        end else begin
          col_nxt = col_inc;
        end
      end
      REQ_INSTR: begin
        q_push   = xfer;
        q_job.b0 = in_req.value;
      end
      REQ_SETCUR: begin
        q_push   = xfer;
        q_job.b0 = ddram_cmd(in_req.row, in_req.col);
        col_nxt  = in_req.col;
        row_nxt  = in_req.row;
      end
      REQ_HOME: begin
        q_push   = xfer;
        q_job.b0 = CMD_HOME;
        col_nxt  = '0;
        row_nxt  = '0;
      end
      REQ_CLEAR: begin
        q_push   = xfer;
        q_job.b0 = CMD_CLEAR;
      end
      REQ_BACKLIGHT: begin
        q_push      = xfer;
        q_job.bl    = 1'b1;
        q_job.bl_on = (in_req.value != '0);
      end
      default: begin
        // unused codes: taken and dropped
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (xfer) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* design/clx_queue.sv */
module clx_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  clx_pkg::job_t  push_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output clx_pkg::job_t  head
);
  import clx_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= inc(rd_ptr_r);
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_ptrs_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

/* design/clx_back.sv */
module clx_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  clx_pkg::job_t               q_head,
  output logic                        q_pop,
  input  logic [clx_pkg::ADDR_W-1:0]  expander_address,
  clx_byte_if.source                  out_byte
);
  import clx_pkg::*;

  logic [BYTE_W-1:0] pin_r, pin_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic              nib_r, nib_nxt;
  logic              bsel_r, bsel_nxt;
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r;
  logic [ADDR_W-1:0] oa_r;
  logic              ol_r;

  logic              advance, last;
  logic [BYTE_W-1:0] cur, emit;
  logic [3:0]        nib;
  logic              rs, end_byte;

  assign advance = q_valid && (!ov_r || out_byte.ready);
  assign q_pop   = advance && last;

  always_comb begin
    cur      = bsel_r ? q_head.b1 : q_head.b0;
    rs       = bsel_r ? 1'b0 : q_head.rs0;
    nib      = nib_r ? cur[3:0] : cur[7:4];
    end_byte = nib_r && (phase_r == 2'd2);
    if (q_head.bl) begin
      emit = pin_r;
      emit[PIN_BL] = q_head.bl_on;
      last = 1'b1;
    end else begin
      emit = {nib, pin_r[3:0]};
      emit[PIN_E]  = (phase_r == 2'd1);
      emit[PIN_RS] = rs;
      last = end_byte && (bsel_r || !q_head.two);
    end
  end

  always_comb begin
    pin_nxt   = pin_r;
    phase_nxt = phase_r;
    nib_nxt   = nib_r;
    bsel_nxt  = bsel_r;
    ov_nxt    = ov_r && !out_byte.ready;
    if (advance) begin
      pin_nxt = emit;
      ov_nxt  = 1'b1;
      if (last) begin
        phase_nxt = '0;
        nib_nxt   = 1'b0;
        bsel_nxt  = 1'b0;
      end else if (phase_r == 2'd2) begin
        phase_nxt = '0;
        nib_nxt   = !nib_r;
        if (nib_r) bsel_nxt = 1'b1;
      end else begin
        phase_nxt = phase_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r   <= '0;
      phase_r <= '0;
      nib_r   <= 1'b0;
      bsel_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      pin_r   <= pin_nxt;
      phase_r <= phase_nxt;
      nib_r   <= nib_nxt;
      bsel_r  <= bsel_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ob_r <= emit;
      oa_r <= expander_address;
      ol_r <= last;
    end
  end

  assign out_byte.valid         = ov_r;
  assign out_byte.expander_byte = ob_r;
  assign out_byte.bus_address   = oa_r;
  assign out_byte.last          = ol_r;

  a_last_e_low: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ol_r) |-> !ob_r[PIN_E])
    else $error("request ended with E high");

  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> (phase_r == '0 && !nib_r && !bsel_r))
    else $error("sequencer mid-job with empty queue");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("strobe phase out of range");

  a_pin_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(advance) |-> (pin_r == ob_r))
    else $error("pin image differs from last byte sent");

endmodule

/* design/char_lcd_expander_sequencer.sv */
// Channel   Dir  Ports                      Transfer when
// in_req    in   req_type value col row     in_req.valid & in_req.ready
// out_byte  out  expander_byte bus_address  out_byte.valid & out_byte.ready
//                last
// cfg       in   APB psel/penable/pwrite    psel & penable & pwrite (pready=1)
//
// One expander byte per cycle while out_byte is ready: a request emits 6 bytes
// (LCD byte), 12 (data with cursor wrap) or 1 (backlight); the back end's
// single-byte output register sets the pace. Requests are taken back to back
// while the queue has room, so a new one is accepted while earlier ones emit.
// Reset (synchronous, rst_n low) clears cursor, pin image and queue, and
// returns the config to address 0, 2 rows, 16 columns.
// A stall on out_byte holds the output register; the queue then fills and
// in_req.ready drops.
module char_lcd_expander_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  clx_req_if.sink                       in_req,
  clx_byte_if.source                    out_byte,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [clx_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [clx_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [clx_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import clx_pkg::*;

  // config registers
  logic [ADDR_W-1:0]  exp_addr_r;
  logic [DROWS_W-1:0] rows_r;
  logic [COL_W-1:0]   cols_r;
  logic               cfg_wr;

  // front -> queue -> back
  job_t push_job, head_job;
  logic push, pop, full, not_empty;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r <= '0;
      rows_r     <= ROWS_RST;
      cols_r     <= COLS_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_EXP_ADDR: exp_addr_r <= cfg_pwdata[ADDR_W-1:0];
        REG_ROWS:     rows_r     <= cfg_pwdata[DROWS_W-1:0];
        REG_COLS:     cols_r     <= cfg_pwdata[COL_W-1:0];
        default: begin
          // beyond the register list: ignored
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_EXP_ADDR: cfg_prdata = {{(CFG_DW-ADDR_W){1'b0}}, exp_addr_r};
      REG_ROWS:     cfg_prdata = {{(CFG_DW-DROWS_W){1'b0}}, rows_r};
      REG_COLS:     cfg_prdata = {{(CFG_DW-COL_W){1'b0}}, cols_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // front: takes requests, tracks the cursor, builds jobs
  clx_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_req       (in_req),
    .display_rows (rows_r),
    .display_cols (cols_r),
    .q_full       (full),
    .q_push       (push),
    .q_job        (push_job)
  );

  // short job queue decoupling the two halves
  clx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head_job)
  );

  // back: nibble/strobe sequencer and pin image, one byte per transfer
  clx_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (not_empty),
    .q_head           (head_job),
    .q_pop            (pop),
    .expander_address (exp_addr_r),
    .out_byte         (out_byte)
  );

endmodule
